// ===== sv/msc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msc_pkg
// Shared types and constants of the MESI snooping cache controller
// ----------------------------------------------------------------------------
package msc_pkg;

   localparam int ADDR_W      = 32;
   localparam int CNT_W       = 32;
   localparam int QUEUE_DEPTH = 2;

   // action codes on the request channel
   localparam logic [2:0] ACT_READ       = 3'd0;
   localparam logic [2:0] ACT_WRITE      = 3'd1;
   localparam logic [2:0] ACT_FILL       = 3'd2;
   localparam logic [2:0] ACT_SNOOP      = 3'd3;
   localparam logic [2:0] ACT_TICK       = 3'd4;
   localparam logic [2:0] ACT_INV_SHARED = 3'd5;

   // bus transaction kinds
   localparam logic [1:0] BUS_RD      = 2'd0;
   localparam logic [1:0] BUS_RDX     = 2'd1;
   localparam logic [1:0] BUS_RDWITWR = 2'd2;
   localparam logic [1:0] BUS_UPGR    = 2'd3;

   // configuration register indexes
   localparam logic CSR_OWN_ID      = 1'b0;
   localparam logic CSR_MEM_LATENCY = 1'b1;

   localparam logic [7:0] AGE_MAX       = 8'd255;
   localparam logic [7:0] MEM_LAT_RESET = 8'd100;

   typedef enum logic [2:0] {
      OP_READ, OP_WRITE, OP_FILL, OP_SNOOP, OP_TICK, OP_INV_SHARED, OP_NONE
   } op_type;

   typedef enum logic [1:0] {ST_I, ST_S, ST_E, ST_M} mesi_type;

   typedef enum logic {BK_IDLE, BK_EXEC} back_state_type;

   // classified transaction between front and back
   typedef struct packed {
      op_type              op;
      logic [ADDR_W-1:0]   address;
      logic [1:0]          bus_kind;
      logic [7:0]          delay;
      logic [2:0]          source_id;
   } req_item_type;

   // result fields, last member in the lowest bits
   typedef struct packed {
      logic [CNT_W-1:0]  traffic_bytes;
      logic [CNT_W-1:0]  invalidation_count;
      logic [CNT_W-1:0]  writeback_count;
      logic [CNT_W-1:0]  eviction_count;
      logic [CNT_W-1:0]  miss_count;
      logic              holds_clean_copy;
      logic              pending;
      logic [ADDR_W-1:0] issue_address;
      logic [1:0]        issue_kind;
      logic              issue_valid;
      logic              hit;
   } rsp_item_type;

endpackage
`default_nettype wire

// ===== sv/mesi_snooping_cache.sv =====
`default_nettype none
// the back handles one transaction at a time: it reads the set from the
//    single-port set memory, then updates it and writes it back; completion
//    waits while an earlier result is still held and not yet taken
// a 2-entry queue decouples request acceptance from execution
// reset: synchronous; clears line valid bits, miss tracking, counters and
//    queue at once, no memory clearing pass; own_id 0, memory_latency 100
// ----------------------------------------------------------------------------
// mesi_snooping_cache
// Set-associative cache tag and MESI coherence controller with age LRU
// ----------------------------------------------------------------------------
module mesi_snooping_cache import msc_pkg::*; #(
   parameter int SET_BITS   = 6,
   parameter int WAYS       = 2,
   parameter int BLOCK_BITS = 5
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // address[31:0], bus_kind[33:32], delay[41:34], source_id[44:42]
   input  wire logic [47:0]   req_tdata,
   // action[2:0]
   input  wire logic [2:0]    req_tuser,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // hit, issue_valid, issue_kind[3:2], issue_address[35:4], pending,
   // holds_clean_copy, miss_count, eviction_count, writeback_count,
   // invalidation_count, traffic_bytes[197:166]
   output logic [199:0]       rsp_tdata,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic          csr_index,
   input  wire logic [7:0]    csr_data
);

   logic          q_valid;
   logic          q_pop;
   req_item_type  q_item;
   rsp_item_type  rsp_item;
   logic [2:0]    own_id_ff;
   logic [7:0]    mem_lat_ff;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff  <= '0;
         mem_lat_ff <= MEM_LAT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_OWN_ID:      own_id_ff  <= csr_data[2:0];
            CSR_MEM_LATENCY: mem_lat_ff <= csr_data;
            default: ;
         endcase
      end
   end

   msc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_action    (req_tuser),
      .req_address   (req_tdata[31:0]),
      .req_bus_kind  (req_tdata[33:32]),
      .req_delay     (req_tdata[41:34]),
      .req_source_id (req_tdata[44:42]),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (q_pop)
   );

   msc_back #(
      .SET_BITS   (SET_BITS),
      .WAYS       (WAYS),
      .BLOCK_BITS (BLOCK_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop),
      .own_id         (own_id_ff),
      .memory_latency (mem_lat_ff),
      .rsp_valid      (rsp_tvalid),
      .rsp_item       (rsp_item),
      .rsp_ready      (rsp_tready)
   );

   assign rsp_tdata = {2'b00, rsp_item};

endmodule
`default_nettype wire

// ===== sv/msc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msc_front
// Accepts request transactions, classifies the action and queues them
// ----------------------------------------------------------------------------
module msc_front import msc_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [2:0]   req_action,
   input  wire logic [31:0]  req_address,
   input  wire logic [1:0]   req_bus_kind,
   input  wire logic [7:0]   req_delay,
   input  wire logic [2:0]   req_source_id,
   output logic              q_valid,
   output req_item_type      q_item,
   input  wire logic         q_pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

   req_item_type        fifo_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0]   count_ff, count_in;
   req_item_type        new_item;
   logic                push;

   // classify the action
   always_comb begin
      new_item.address   = req_address;
      new_item.bus_kind  = req_bus_kind;
      new_item.delay     = req_delay;
      new_item.source_id = req_source_id;
      case (req_action)
         ACT_READ:       new_item.op = OP_READ;
         ACT_WRITE:      new_item.op = OP_WRITE;
         ACT_FILL:       new_item.op = OP_FILL;
         ACT_SNOOP:      new_item.op = OP_SNOOP;
         ACT_TICK:       new_item.op = OP_TICK;
         ACT_INV_SHARED: new_item.op = OP_INV_SHARED;
         default:        new_item.op = OP_NONE;
      endcase
   end

   // queue control
   assign req_tready = (count_ff != CNT_QW'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != '0);
   assign q_item     = fifo_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule
`default_nettype wire

// ===== sv/msc_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msc_back
// Reads one set, applies the transaction to tags, MESI state and ages,
// writes the set back and registers the result
// ----------------------------------------------------------------------------
module msc_back import msc_pkg::*; #(
   parameter int SET_BITS   = 6,
   parameter int WAYS       = 2,
   parameter int BLOCK_BITS = 5
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         q_valid,
   input  wire req_item_type q_item,
   output logic              q_pop,
   input  wire logic [2:0]   own_id,
   input  wire logic [7:0]   memory_latency,
   output logic              rsp_valid,
   output rsp_item_type      rsp_item,
   input  wire logic         rsp_ready
);

   localparam int NUM_SETS  = 1 << SET_BITS;
   localparam int SET_W     = (SET_BITS > 0) ? SET_BITS : 1;
   localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int TAG_W     = ADDR_W - SET_BITS - BLOCK_BITS;
   localparam int ENTRY_W   = TAG_W + 10;
   localparam int CNT_INC_W = $clog2(WAYS + 2);

   typedef logic [WAYS-1:0][ENTRY_W-1:0] row_type;

   row_type              row_mem [NUM_SETS];
   row_type              row_ff;
   row_type              row_new;
   logic [WAYS-1:0]      valid_ff [NUM_SETS];
   back_state_type       state_ff, state_in;
   req_item_type         item_ff;
   logic [SET_W-1:0]     set_ff, q_set;
   logic                 miss_ff, miss_in;
   logic [ADDR_W-1:0]    out_addr_ff, out_addr_in;
   logic                 await_ff, await_in;
   logic [7:0]           delay_ff, delay_in;
   logic [CNT_W-1:0]     miss_cnt_ff, evict_cnt_ff, wb_cnt_ff, inv_cnt_ff, traffic_ff;
   logic                 rsp_valid_ff;
   rsp_item_type         rsp_ff, rsp_new;
   logic                 exec_done;

   // per-way view of the set
   logic [TAG_W-1:0]     tg   [WAYS];
   mesi_type             st   [WAYS];
   logic [7:0]           ag   [WAYS];
   logic [WAYS-1:0]      vl;
   logic [TAG_W-1:0]     n_tg [WAYS];
   mesi_type             n_st [WAYS];
   logic [7:0]           n_ag [WAYS];
   logic [WAYS-1:0]      n_vl;
   logic [TAG_W-1:0]     tag_in;
   logic [WAYS-1:0]      match;
   logic                 hit_any;
   logic [WAY_W-1:0]     hit_way;
   logic                 touch_en;
   logic [WAY_W-1:0]     touch_way;
   logic                 found;
   logic [WAY_W-1:0]     victim;
   logic                 hit_o, iv_o, clean_o;
   logic [1:0]           ik_o;
   logic                 inc_miss, inc_evict;
   logic [CNT_INC_W-1:0] inc_wb, inc_inv, inc_blocks;

   function automatic logic [SET_W-1:0] set_of(input logic [ADDR_W-1:0] a);
      set_of = SET_W'((a >> BLOCK_BITS) & ADDR_W'(NUM_SETS - 1));
   endfunction

   assign q_set  = set_of(q_item.address);
   assign tag_in = item_ff.address[ADDR_W-1 -: TAG_W];

   // back state machine: next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: if (q_valid) state_in = BK_EXEC;
         BK_EXEC: if (exec_done) state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   // back state machine: outputs
   always_comb begin
      q_pop     = 1'b0;
      exec_done = 1'b0;
      case (state_ff)
         BK_IDLE: q_pop = q_valid;
         BK_EXEC: exec_done = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   // unpack the set read
   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         vl[w] = valid_ff[set_ff][w];
         tg[w] = row_ff[w][ENTRY_W-1:10];
         st[w] = vl[w] ? mesi_type'(row_ff[w][9:8]) : ST_I;
         ag[w] = row_ff[w][7:0];
         match[w] = vl[w] && (tg[w] == tag_in);
      end
   end

   // first matching way
   always_comb begin
      hit_any = 1'b0;
      hit_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (match[w]) begin
            hit_any = 1'b1;
            hit_way = WAY_W'(w);
         end
      end
   end

   // fill victim: first invalid way, else lowest way with largest age
   always_comb begin
      found  = 1'b0;
      victim = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (!found) begin
            if (!vl[w]) begin
               victim = WAY_W'(w);
               found  = 1'b1;
            end else if (ag[w] > ag[victim]) begin
               victim = WAY_W'(w);
            end
         end
      end
   end

   // transaction execution
   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         n_tg[w] = tg[w];
         n_st[w] = st[w];
         n_ag[w] = ag[w];
      end
      n_vl        = vl;
      miss_in     = miss_ff;
      out_addr_in = out_addr_ff;
      await_in    = await_ff;
      delay_in    = delay_ff;
      hit_o       = 1'b0;
      iv_o        = 1'b0;
      ik_o        = BUS_RD;
      touch_en    = 1'b0;
      touch_way   = '0;
      inc_miss    = 1'b0;
      inc_evict   = 1'b0;
      inc_wb      = '0;
      inc_inv     = '0;
      inc_blocks  = '0;
      case (item_ff.op)
         OP_READ, OP_WRITE: begin
            if (!miss_ff) begin
               if (hit_any) begin
                  if (item_ff.op == OP_WRITE) begin
                     if (st[hit_way] == ST_S) begin
                        iv_o = 1'b1;
                        ik_o = BUS_UPGR;
                     end
                     n_st[hit_way] = ST_M;
                  end
                  touch_en  = 1'b1;
                  touch_way = hit_way;
                  hit_o     = 1'b1;
               end else begin
                  iv_o        = 1'b1;
                  ik_o        = (item_ff.op == OP_WRITE) ? BUS_RDWITWR : BUS_RD;
                  miss_in     = 1'b1;
                  out_addr_in = item_ff.address;
                  await_in    = 1'b1;
                  delay_in    = '0;
                  inc_miss    = 1'b1;
               end
            end
         end
         OP_FILL: begin
            if (miss_ff && out_addr_ff == item_ff.address && await_ff) begin
               await_in   = 1'b0;
               delay_in   = item_ff.delay;
               if (item_ff.delay == '0) miss_in = 1'b0;
               inc_blocks = CNT_INC_W'(1);
               inc_evict  = (item_ff.delay == memory_latency);
               if (vl[victim] && st[victim] == ST_M) inc_wb = CNT_INC_W'(1);
               n_tg[victim] = tag_in;
               n_vl[victim] = 1'b1;
               if (item_ff.bus_kind == BUS_RD) begin
                  n_st[victim] = (item_ff.delay == memory_latency) ? ST_E : ST_S;
               end else begin
                  n_st[victim] = ST_M;
               end
               touch_en  = 1'b1;
               touch_way = victim;
            end
         end
         OP_SNOOP: begin
            if (item_ff.source_id != own_id) begin
               for (int w = 0; w < WAYS; w++) begin
                  if (match[w]) begin
                     if (item_ff.bus_kind == BUS_RD) begin
                        if (st[w] == ST_M) begin
                           inc_wb     = inc_wb + 1'b1;
                           inc_blocks = inc_blocks + 1'b1;
                        end
                        if (st[w] == ST_M || st[w] == ST_E) n_st[w] = ST_S;
                     end else begin
                        n_st[w] = ST_I;
                        n_vl[w] = 1'b0;
                        inc_inv = inc_inv + 1'b1;
                     end
                  end
               end
            end
         end
         OP_TICK: begin
            if (miss_ff && !await_ff && delay_ff != '0) begin
               delay_in = delay_ff - 1'b1;
               if (delay_ff == 8'd1) miss_in = 1'b0;
            end
         end
         OP_INV_SHARED: begin
            for (int w = 0; w < WAYS; w++) begin
               if (match[w] && st[w] == ST_S) begin
                  n_st[w] = ST_I;
                  n_vl[w] = 1'b0;
               end
            end
         end
         default: ;
      endcase
      // age update: the touched way becomes youngest, other valid ways age up to AGE_MAX
      if (touch_en) begin
         for (int w = 0; w < WAYS; w++) begin
            if (WAY_W'(w) == touch_way) begin
               n_ag[w] = '0;
            end else if (n_vl[w] && ag[w] != AGE_MAX) begin
               n_ag[w] = ag[w] + 1'b1;
            end
         end
      end
      // clean copy after the update
      clean_o = 1'b0;
      for (int w = 0; w < WAYS; w++) begin
         if (n_vl[w] && n_tg[w] == tag_in && (n_st[w] == ST_S || n_st[w] == ST_E)) begin
            clean_o = 1'b1;
         end
         row_new[w] = {n_tg[w], n_st[w], n_ag[w]};
      end
   end

   // result assembly
   always_comb begin
      rsp_new.hit                = hit_o;
      rsp_new.issue_valid        = iv_o;
      rsp_new.issue_kind         = iv_o ? ik_o : BUS_RD;
      rsp_new.issue_address      = iv_o ? item_ff.address : '0;
      rsp_new.pending            = miss_in;
      rsp_new.holds_clean_copy   = clean_o;
      rsp_new.miss_count         = miss_cnt_ff + CNT_W'(inc_miss);
      rsp_new.eviction_count     = evict_cnt_ff + CNT_W'(inc_evict);
      rsp_new.writeback_count    = wb_cnt_ff + CNT_W'(inc_wb);
      rsp_new.invalidation_count = inv_cnt_ff + CNT_W'(inc_inv);
      rsp_new.traffic_bytes      = traffic_ff + (CNT_W'(inc_blocks) << BLOCK_BITS);
   end

   // set memory: read on pop, write back on completion
   always_ff @(posedge clock) begin
      if (q_pop) begin
         row_ff  <= row_mem[q_set];
         item_ff <= q_item;
         set_ff  <= q_set;
      end
      if (exec_done) begin
         row_mem[set_ff] <= row_new;
      end
   end

   // control state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         miss_ff      <= 1'b0;
         out_addr_ff  <= '0;
         await_ff     <= 1'b0;
         delay_ff     <= '0;
         miss_cnt_ff  <= '0;
         evict_cnt_ff <= '0;
         wb_cnt_ff    <= '0;
         inv_cnt_ff   <= '0;
         traffic_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < NUM_SETS; s++) begin
            valid_ff[s] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (exec_done) begin
            miss_ff          <= miss_in;
            out_addr_ff      <= out_addr_in;
            await_ff         <= await_in;
            delay_ff         <= delay_in;
            miss_cnt_ff      <= rsp_new.miss_count;
            evict_cnt_ff     <= rsp_new.eviction_count;
            wb_cnt_ff        <= rsp_new.writeback_count;
            inv_cnt_ff       <= rsp_new.invalidation_count;
            traffic_ff       <= rsp_new.traffic_bytes;
            valid_ff[set_ff] <= n_vl;
            rsp_valid_ff     <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (exec_done) begin
         rsp_ff <= rsp_new;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule
`default_nettype wire

// ===== sv/msc_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msc_checker
// Port-level checks of the MESI snooping cache result stream
// ----------------------------------------------------------------------------
module msc_checker (
   input wire logic          clock,
   input wire logic          reset,
   input wire logic          rsp_tvalid,
   input wire logic          rsp_tready,
   input wire logic [199:0]  rsp_tdata
);

   // stalled result transaction holds its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

   // nothing comes out right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a hit only issues an upgrade
   a_hit_upgr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] && rsp_tdata[1] |-> rsp_tdata[3:2] == 2'd3)
      else $error("hit issued a non-upgrade transaction");

   // no issue means zero kind and address
   a_no_issue: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[1] |-> rsp_tdata[35:2] == '0)
      else $error("issue fields set without issue");

endmodule

bind mesi_snooping_cache msc_checker u_msc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

// ===== tb/mesi_snooping_cache_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mesi_snooping_cache_tb
// Self-checking bench for the MESI snooping cache controller: a queue-fed
// driver sends reads, writes, fills, snoops, ticks and the other actions, a
// local coherence model predicts every response, a monitor checks each field
// ----------------------------------------------------------------------------
module mesi_snooping_cache_tb import msc_pkg::*;;

   localparam int LINES     = 128;
   localparam int MAX_CYCLE = 300000;

   typedef struct {
      logic [2:0]  action;
      logic [31:0] address;
      logic [1:0]  kind;
      logic [7:0]  dly;
      logic [2:0]  src;
   } cache_req_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [47:0]  req_tdata = '0;
   logic [2:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [199:0] rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic         csr_index = 1'b0;
   logic [7:0]   csr_data = '0;

   mesi_snooping_cache dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // coherence model state
   logic [20:0]  tag_mem [LINES];
   logic         valid_mem [LINES];
   logic         dirty_mem [LINES];
   mesi_type     mesi_mem [LINES];
   logic [7:0]   age_mem [LINES];
   logic         miss_busy;
   logic [31:0]  miss_addr;
   logic         fill_wait;
   logic [7:0]   fill_left;
   logic [31:0]  n_miss, n_evict, n_wb, n_inv, n_traffic;
   logic [2:0]   my_id = 3'd0;
   logic [7:0]   mem_lat = MEM_LAT_RESET;

   cache_req_type pending_reqs[$];
   rsp_item_type  expected_rsps[$];
   int            errors = 0;
   int            cycles = 0;
   int            idle_mode = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   // refresh ages in a set, way becomes the youngest
   function automatic void age_touch(int base, int way);
      age_mem[base + way] = 8'd0;
      for (int i = 0; i < 2; i++)
         if (i != way && valid_mem[base + i] && age_mem[base + i] != AGE_MAX)
            age_mem[base + i]++;
   endfunction

   function automatic rsp_item_type cache_predict(cache_req_type r);
      rsp_item_type o;
      int           base;
      int           way;
      int           victim;
      logic [20:0]  t;
      base   = int'(r.address[10:5]) * 2;
      t      = r.address[31:11];
      o      = '0;
      way    = -1;
      victim = 0;
      for (int i = 1; i >= 0; i--)
         if (valid_mem[base + i] && tag_mem[base + i] == t) way = i;
      case (r.action)
         ACT_READ, ACT_WRITE: begin
            if (!miss_busy) begin
               if (way >= 0) begin
                  if (r.action == ACT_WRITE) begin
                     if (mesi_mem[base + way] == ST_S) begin
                        o.issue_valid = 1'b1;
                        o.issue_kind  = BUS_UPGR;
                     end
                     dirty_mem[base + way] = 1'b1;
                     mesi_mem[base + way]  = ST_M;
                  end
                  age_touch(base, way);
                  o.hit = 1'b1;
               end else begin
                  o.issue_valid = 1'b1;
                  o.issue_kind  = (r.action == ACT_WRITE) ? BUS_RDWITWR : BUS_RD;
                  miss_busy = 1'b1;
                  miss_addr = r.address;
                  fill_wait = 1'b1;
                  fill_left = 8'd0;
                  n_miss++;
               end
            end
         end
         ACT_FILL: begin
            if (miss_busy && miss_addr == r.address && fill_wait) begin
               fill_wait = 1'b0;
               fill_left = r.dly;
               if (r.dly == 8'd0) miss_busy = 1'b0;
               n_traffic += 32;
               if (r.dly == mem_lat) n_evict++;
               for (int w = 0; w < 2; w++) begin
                  if (!valid_mem[base + w]) begin
                     victim = w;
                     break;
                  end
                  if (age_mem[base + w] > age_mem[base + victim]) victim = w;
               end
               if (valid_mem[base + victim] && dirty_mem[base + victim]) n_wb++;
               tag_mem[base + victim]   = t;
               valid_mem[base + victim] = 1'b1;
               if (r.kind == BUS_RD) begin
                  dirty_mem[base + victim] = 1'b0;
                  mesi_mem[base + victim]  = (r.dly == mem_lat) ? ST_E : ST_S;
               end else begin
                  dirty_mem[base + victim] = 1'b1;
                  mesi_mem[base + victim]  = ST_M;
               end
               age_touch(base, victim);
            end
         end
         ACT_SNOOP: begin
            if (r.src != my_id)
               for (int w = 0; w < 2; w++) begin
                  if (!valid_mem[base + w] || tag_mem[base + w] != t) continue;
                  if (r.kind == BUS_RD) begin
                     if (mesi_mem[base + w] == ST_M) begin
                        n_wb++;
                        n_traffic += 32;
                     end
                     if (mesi_mem[base + w] inside {ST_M, ST_E}) begin
                        mesi_mem[base + w]  = ST_S;
                        dirty_mem[base + w] = 1'b0;
                     end
                  end else begin
                     mesi_mem[base + w]  = ST_I;
                     valid_mem[base + w] = 1'b0;
                     dirty_mem[base + w] = 1'b0;
                     n_inv++;
                  end
               end
         end
         ACT_TICK: begin
            if (miss_busy && !fill_wait && fill_left != 8'd0) begin
               fill_left--;
               if (fill_left == 8'd0) miss_busy = 1'b0;
            end
         end
         ACT_INV_SHARED: begin
            for (int w = 0; w < 2; w++)
               if (valid_mem[base + w] && tag_mem[base + w] == t &&
                   mesi_mem[base + w] == ST_S) begin
                  mesi_mem[base + w]  = ST_I;
                  valid_mem[base + w] = 1'b0;
                  dirty_mem[base + w] = 1'b0;
               end
         end
         default: ;
      endcase
      for (int w = 0; w < 2; w++)
         if (valid_mem[base + w] && tag_mem[base + w] == t &&
             mesi_mem[base + w] inside {ST_S, ST_E})
            o.holds_clean_copy = 1'b1;
      o.issue_address      = o.issue_valid ? r.address : 32'd0;
      o.pending            = miss_busy;
      o.miss_count         = n_miss;
      o.eviction_count     = n_evict;
      o.writeback_count    = n_wb;
      o.invalidation_count = n_inv;
      o.traffic_bytes      = n_traffic;
      return o;
   endfunction

   // request driver
   always @(posedge clock) begin
      cache_req_type r;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            r.address = req_tdata[31:0];
            r.kind    = req_tdata[33:32];
            r.dly     = req_tdata[41:34];
            r.src     = req_tdata[44:42];
            r.action  = req_tuser;
            expected_rsps.push_back(cache_predict(r));
         end
         if (!req_tvalid || req_tready) begin
            if (pending_reqs.size() != 0 &&
                $urandom_range(99) >= (idle_mode == 0 ? 6 : idle_mode == 1 ? 52 : 0)) begin
               r = pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {3'b000, r.src, r.dly, r.kind, r.address};
               req_tuser  <= r.action;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
         errors++;
      end
   endfunction

   // response monitor
   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_item_type'(rsp_tdata[197:0]);
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual %h", $time, got);
            errors++;
         end else begin
            want = expected_rsps.pop_front();
            check_field("hit", want.hit, got.hit);
            check_field("issue_valid", want.issue_valid, got.issue_valid);
            check_field("issue_kind", want.issue_kind, got.issue_kind);
            check_field("issue_address", want.issue_address, got.issue_address);
            check_field("pending", want.pending, got.pending);
            check_field("holds_clean_copy", want.holds_clean_copy, got.holds_clean_copy);
            check_field("miss_count", want.miss_count, got.miss_count);
            check_field("eviction_count", want.eviction_count, got.eviction_count);
            check_field("writeback_count", want.writeback_count, got.writeback_count);
            check_field("invalidation_count", want.invalidation_count,
                        got.invalidation_count);
            check_field("traffic_bytes", want.traffic_bytes, got.traffic_bytes);
         end
      end
      rsp_tready <= reset ? 1'b0 :
                    ($urandom_range(99) >= (idle_mode == 0 ? 52 : idle_mode == 1 ? 6 : 0));
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > MAX_CYCLE) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic void add_req(logic [2:0] action, logic [31:0] address,
                                   logic [1:0] kind, logic [7:0] dly, logic [2:0] src);
      cache_req_type r;
      r.action  = action;
      r.address = address;
      r.kind    = kind;
      r.dly     = dly;
      r.src     = src;
      pending_reqs.push_back(r);
   endfunction

   // addresses from a few sets and tags so lines conflict and get evicted
   function automatic logic [31:0] pool_addr();
      logic [31:0] a;
      a        = $urandom;
      a[10:5]  = ($urandom_range(3) == 0) ? 6'h3f : 6'($urandom_range(2));
      a[31:11] = ($urandom_range(4) == 0) ? 21'h1fffff : 21'($urandom_range(3));
      return a;
   endfunction

   // mostly access, fill, tick sequences; snoops and noise in between
   function automatic void add_random(int count);
      logic [31:0] a;
      logic [7:0]  d;
      int          n;
      int          sel;
      n = 0;
      while (n < count) begin
         sel = $urandom_range(99);
         a   = pool_addr();
         if (sel < 60) begin
            d = ($urandom_range(9) == 0) ? mem_lat : 8'($urandom_range(4));
            if ($urandom_range(29) == 0) d = 8'($urandom_range(255, 20));
            add_req($urandom_range(1) ? ACT_WRITE : ACT_READ, a, 2'($urandom),
                    8'($urandom), 3'($urandom));
            if ($urandom_range(9) == 0)
               add_req(ACT_READ, pool_addr(), 2'($urandom), 8'($urandom), 3'($urandom));
            add_req(ACT_FILL, a, 2'($urandom_range(3)), d, 3'($urandom));
            for (int i = 0; i < int'(d) + $urandom_range(1); i++)
               add_req(ACT_TICK, $urandom, 2'($urandom), 8'($urandom), 3'($urandom));
            n += 3 + int'(d);
         end else if (sel < 80) begin
            add_req(ACT_SNOOP, a, 2'($urandom), 8'($urandom), 3'($urandom));
            n++;
         end else if (sel < 88) begin
            add_req(ACT_INV_SHARED, a, 2'($urandom), 8'($urandom), 3'($urandom));
            n++;
         end else begin
            add_req(3'($urandom), ($urandom_range(1) ? $urandom : a), 2'($urandom),
                    8'($urandom), 3'($urandom));
            n++;
         end
      end
   endfunction

   task automatic write_csr(logic index, logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (index == CSR_OWN_ID) my_id = value[2:0];
      else mem_lat = value;
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_tvalid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   initial begin
      logic [31:0] a0;
      logic [31:0] a1;
      for (int i = 0; i < LINES; i++) begin
         tag_mem[i]   = '0;
         valid_mem[i] = 1'b0;
         dirty_mem[i] = 1'b0;
         mesi_mem[i]  = ST_I;
         age_mem[i]   = 8'd0;
      end
      miss_busy = 1'b0;
      miss_addr = '0;
      fill_wait = 1'b0;
      fill_left = '0;
      {n_miss, n_evict, n_wb, n_inv, n_traffic} = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // phase 0: directed corner cases, then random traffic
      idle_mode = 0;
      write_csr(CSR_OWN_ID, 8'd7);
      write_csr(CSR_MEM_LATENCY, 8'd0);
      a0 = 32'h0000_0000;
      a1 = 32'h0000_0800;
      add_req(ACT_READ, a0, BUS_RD, 8'd0, 3'd0);
      add_req(ACT_FILL, a0, BUS_RD, 8'd0, 3'd0);
      add_req(ACT_TICK, a0, BUS_RD, 8'd0, 3'd0);
      add_req(ACT_READ, a1, BUS_RD, 8'd0, 3'd0);
      add_req(ACT_WRITE, a0, BUS_RD, 8'd0, 3'd0);
      add_req(ACT_FILL, a0, BUS_RD, 8'd2, 3'd0);
      add_req(ACT_FILL, a1, BUS_RD, 8'd2, 3'd0);
      add_req(ACT_FILL, a1, BUS_RD, 8'd2, 3'd0);
      add_req(ACT_TICK, a1, BUS_RD, 8'd0, 3'd0);
      add_req(ACT_READ, a0, BUS_RD, 8'd0, 3'd0);
      add_req(ACT_TICK, a1, BUS_RD, 8'd0, 3'd0);
      add_req(ACT_WRITE, a0, BUS_RD, 8'd0, 3'd0);
      add_req(ACT_SNOOP, a0, BUS_RD, 8'd0, 3'd1);
      add_req(ACT_WRITE, a0, BUS_RD, 8'd0, 3'd0);
      add_req(ACT_SNOOP, a0, BUS_RDX, 8'd0, 3'd7);
      add_req(ACT_SNOOP, a1, BUS_RD, 8'd0, 3'd2);
      add_req(ACT_INV_SHARED, a1, BUS_RD, 8'd0, 3'd0);
      add_req(ACT_SNOOP, a0, BUS_UPGR, 8'd0, 3'd3);
      add_req(ACT_WRITE, 32'hffff_ffff, BUS_RD, 8'hff, 3'd7);
      add_req(ACT_FILL, 32'hffff_ffff, BUS_UPGR, 8'd1, 3'd0);
      add_req(ACT_TICK, 32'hffff_ffff, BUS_RD, 8'd0, 3'd0);
      add_req(ACT_SNOOP, 32'hffff_ffff, BUS_RDWITWR, 8'd0, 3'd4);
      add_req(3'd6, 32'hffff_ffff, 2'd3, 8'hff, 3'd7);
      add_req(3'd7, a0, 2'd0, 8'd0, 3'd0);
      wait_drained();
      add_random(220);
      wait_drained();

      // phase 1: receiver mostly ready, sender slow
      idle_mode = 1;
      write_csr(CSR_OWN_ID, 8'd0);
      write_csr(CSR_MEM_LATENCY, 8'd3);
      add_random(220);
      wait_drained();

      // phase 2: no idling, age saturation then random
      idle_mode = 2;
      write_csr(CSR_OWN_ID, 8'd3);
      write_csr(CSR_MEM_LATENCY, 8'd255);
      a0 = 32'h0000_0040;
      a1 = 32'h0000_0840;
      add_req(ACT_READ, a0, BUS_RD, 8'd0, 3'd0);
      add_req(ACT_FILL, a0, BUS_RD, 8'd0, 3'd0);
      add_req(ACT_READ, a1, BUS_RD, 8'd0, 3'd0);
      add_req(ACT_FILL, a1, BUS_RD, 8'd0, 3'd0);
      for (int i = 0; i < 260; i++) add_req(ACT_READ, a1, BUS_RD, 8'd0, 3'd0);
      add_req(ACT_READ, 32'h0000_1040, BUS_RD, 8'd0, 3'd0);
      add_req(ACT_FILL, 32'h0000_1040, BUS_RD, 8'd0, 3'd0);
      add_random(220);
      wait_drained();

      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
